/* hw/rtl/uitf_pkg.sv */
// Shared types and codes for the unique-id task queue.
package uitf_pkg;

  localparam int ID_W  = 16;
  localparam int DUR_W = 8;

  typedef logic [ID_W-1:0]  task_id_t;
  typedef logic [DUR_W-1:0] task_dur_t;

  // Command codes
  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } command_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_DUP   = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_POP  = 4'b0100,
    ST_RESP = 4'b1000
  } state_t;

endpackage

/* hw/rtl/unique_id_task_fifo_unit.sv */
// Circular task queue with a duplicate-id check on push.
//
//   channel | direction | ports                                       | handshake
//   --------+-----------+---------------------------------------------+----------------------
//   in      | input     | in_command, in_task_id, in_task_duration    | in_valid / in_ready
//   out     | output    | out_status, out_id, out_duration            | out_valid / out_ready
//
// One item at a time. A push walks the stored ids through the registered
// id memory read port, one entry per cycle, before its result; an empty or full
// queue skips the walk. A pop reads the head entry, a refused pop skips the
// read. The result sits in an output register, so the next item is
// accepted while it waits for out_ready; a stalled output holds the next result
// in the final state. Synchronous active-low reset empties the queue; the
// stores are not cleared.
module unique_id_task_fifo_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  uitf_pkg::command_t  in_command,
  input  uitf_pkg::task_id_t  in_task_id,
  input  uitf_pkg::task_dur_t in_task_duration,
  output logic                out_valid,
  input  logic                out_ready,
  output uitf_pkg::status_t   out_status,
  output uitf_pkg::task_id_t  out_id,
  output uitf_pkg::task_dur_t out_duration
);
  import uitf_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef logic [IW-1:0] idx_t;
  typedef logic [CW-1:0] cnt_t;

  // Wrapping slot increment
  function automatic idx_t next_slot(input idx_t p);
    next_slot = (p == idx_t'(QUEUE_DEPTH - 1)) ? '0 : idx_t'(p + 1'b1);
  endfunction

  // Storage
  task_id_t  id_mem  [QUEUE_DEPTH];
  task_dur_t dur_mem [QUEUE_DEPTH];
  task_id_t  rd_id_r;
  task_dur_t rd_dur_r;

  // Control and working registers
  state_t    st_r, st_nxt;
  idx_t      head_r, head_nxt;
  idx_t      tail_r, tail_nxt;
  cnt_t      occ_r, occ_nxt;
  idx_t      scan_ptr_r, scan_ptr_nxt;
  cnt_t      iss_cnt_r, iss_cnt_nxt;
  cnt_t      cmp_cnt_r, cmp_cnt_nxt;
  logic      rd_pend_r, rd_pend_nxt;
  task_id_t  id_r, id_nxt;
  task_dur_t dur_r, dur_nxt;
  status_t   res_status_r, res_status_nxt;
  task_id_t  res_id_r, res_id_nxt;
  task_dur_t res_dur_r, res_dur_nxt;
  logic      out_valid_r, out_valid_nxt;
  status_t   out_status_r, out_status_nxt;
  task_id_t  out_id_r, out_id_nxt;
  task_dur_t out_dur_r, out_dur_nxt;

  // Memory port controls
  logic      mem_re;
  idx_t      mem_ra;
  logic      mem_we;
  task_id_t  mem_wid;
  task_dur_t mem_wdur;
  cnt_t      cmp_cnt_sum;

  assign in_ready     = (st_r == ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_id       = out_id_r;
  assign out_duration = out_dur_r;

  assign cmp_cnt_sum  = cmp_cnt_r + cnt_t'(rd_pend_r);

  // Sequencer
  always_comb begin
    st_nxt         = st_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    occ_nxt        = occ_r;
    scan_ptr_nxt   = scan_ptr_r;
    iss_cnt_nxt    = iss_cnt_r;
    cmp_cnt_nxt    = cmp_cnt_r;
    rd_pend_nxt    = rd_pend_r;
    id_nxt         = id_r;
    dur_nxt        = dur_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_dur_nxt    = res_dur_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_dur_nxt    = out_dur_r;
    mem_re         = 1'b0;
    mem_ra         = head_r;
    mem_we         = 1'b0;
    mem_wid        = id_r;
    mem_wdur       = dur_r;

    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          id_nxt      = in_task_id;
          dur_nxt     = in_task_duration;
          res_id_nxt  = '0;
          res_dur_nxt = '0;
          if (in_command == CMD_POP) begin
            if (occ_r == '0) begin
              res_status_nxt = STAT_EMPTY;
              st_nxt         = ST_RESP;
            end else begin
              mem_re = 1'b1;
              st_nxt = ST_POP;
            end
          end else if (occ_r == cnt_t'(QUEUE_DEPTH)) begin
            res_status_nxt = STAT_FULL;
            st_nxt         = ST_RESP;
          end else if (occ_r == '0) begin
            // nothing to check against: store right away
            mem_we         = 1'b1;
            mem_wid        = in_task_id;
            mem_wdur       = in_task_duration;
            tail_nxt       = next_slot(tail_r);
            occ_nxt        = occ_r + 1'b1;
            res_status_nxt = STAT_OK;
            st_nxt         = ST_RESP;
          end else begin
            scan_ptr_nxt = head_r;
            iss_cnt_nxt  = '0;
            cmp_cnt_nxt  = '0;
            rd_pend_nxt  = 1'b0;
            st_nxt       = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // compare the entry read last cycle, issue the next read
        if (rd_pend_r && (rd_id_r == id_r)) begin
          res_status_nxt = STAT_DUP;
          rd_pend_nxt    = 1'b0;
          st_nxt         = ST_RESP;
        end else if (cmp_cnt_sum == occ_r) begin
          mem_we         = 1'b1;
          tail_nxt       = next_slot(tail_r);
          occ_nxt        = occ_r + 1'b1;
          res_status_nxt = STAT_OK;
          rd_pend_nxt    = 1'b0;
          st_nxt         = ST_RESP;
        end else begin
          cmp_cnt_nxt = cmp_cnt_sum;
          if (iss_cnt_r < occ_r) begin
            mem_re       = 1'b1;
            mem_ra       = scan_ptr_r;
            scan_ptr_nxt = next_slot(scan_ptr_r);
            iss_cnt_nxt  = iss_cnt_r + 1'b1;
            rd_pend_nxt  = 1'b1;
          end else begin
            rd_pend_nxt = 1'b0;
          end
        end
      end

      ST_POP: begin
        res_status_nxt = STAT_OK;
        res_id_nxt     = rd_id_r;
        res_dur_nxt    = rd_dur_r;
        head_nxt       = next_slot(head_r);
        occ_nxt        = occ_r - 1'b1;
        st_nxt         = ST_RESP;
      end

      ST_RESP: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          out_dur_nxt    = res_dur_r;
          st_nxt         = ST_IDLE;
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Id and duration memories, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      id_mem[tail_r]  <= mem_wid;
      dur_mem[tail_r] <= mem_wdur;
    end
    if (mem_re) begin
      rd_id_r  <= id_mem[mem_ra];
      rd_dur_r <= dur_mem[mem_ra];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and scan bookkeeping
  always_ff @(posedge clk) begin
    scan_ptr_r   <= scan_ptr_nxt;
    iss_cnt_r    <= iss_cnt_nxt;
    cmp_cnt_r    <= cmp_cnt_nxt;
    id_r         <= id_nxt;
    dur_r        <= dur_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_dur_r    <= res_dur_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_dur_r    <= out_dur_nxt;
  end

endmodule

/* sim/unique_id_task_fifo_unit_test.sv */
// Testbench for the unique-id task queue: directed and random push/pop traffic against a queue predictor.
`timescale 1ns / 100ps

module unique_id_task_fifo_unit_test;
  import uitf_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 1800;
  localparam int PHASE_LEN    = 120;   // accepted items per idling phase
  localparam int IDLE_LIMIT   = 5000;  // cycles without any handshake
  localparam int DRAIN_CYCLES = 40;    // settling time after the last result
  localparam int MAX_REPORTS  = 10;
  localparam int RECENT_IDS   = 20;

  typedef struct packed {
    command_t  cmd;
    task_id_t  id;
    task_dur_t dur;
  } task_cmd_t;

  typedef struct packed {
    status_t   status;
    task_id_t  id;
    task_dur_t dur;
  } task_result_t;

  // DUT ports
  logic      clk              = 1'b0;
  logic      rst_n            = 1'b0;
  logic      in_valid         = 1'b0;
  logic      in_ready;
  command_t  in_command       = CMD_PUSH;
  task_id_t  in_task_id       = '0;
  task_dur_t in_task_duration = '0;
  logic      out_valid;
  logic      out_ready        = 1'b0;
  status_t   out_status;
  task_id_t  out_id;
  task_dur_t out_duration;

  // Stimulus and scoreboard
  task_cmd_t    pending_cmds[$];
  task_result_t expected_results[$];
  task_id_t     pushed_ids[$];
  int           total_cmds     = 0;
  int           accepted_items = 0;
  int           mismatch_count = 0;
  int           quiet_cycles   = 0;

  // Predicted queue contents
  task_id_t  queued_ids[DEPTH];
  task_dur_t queued_durs[DEPTH];
  int        queue_head  = 0;
  int        queue_tail  = 0;
  int        queue_count = 0;

  unique_id_task_fifo_unit #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_task_id       (in_task_id),
    .in_task_duration (in_task_duration),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_id           (out_id),
    .out_duration     (out_duration)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one command to the predicted queue and return its result
  function automatic task_result_t predict_task_result(task_cmd_t c);
    task_result_t r;
    bit           seen;
    r.status = STAT_OK;
    r.id     = '0;
    r.dur    = '0;
    seen     = 1'b0;
    if (c.cmd == CMD_PUSH) begin
      for (int n = 0; n < queue_count; n++) begin
        if (queued_ids[(queue_head + n) % DEPTH] == c.id) seen = 1'b1;
      end
      // full takes priority over duplicate
      if (queue_count >= DEPTH) begin
        r.status = STAT_FULL;
      end else if (seen) begin
        r.status = STAT_DUP;
      end else begin
        queued_ids[queue_tail]  = c.id;
        queued_durs[queue_tail] = c.dur;
        queue_tail  = (queue_tail + 1) % DEPTH;
        queue_count = queue_count + 1;
      end
    end else begin
      if (queue_count == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        r.id        = queued_ids[queue_head];
        r.dur       = queued_durs[queue_head];
        queue_head  = (queue_head + 1) % DEPTH;
        queue_count = queue_count - 1;
      end
    end
    return r;
  endfunction

  // Idling phases: none, sender idle, receiver stall, both
  function automatic int sender_idle_pct();
    case ((accepted_items / PHASE_LEN) % 4)
      1: return 47;
      3: return 25;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case ((accepted_items / PHASE_LEN) % 4)
      2: return 47;
      3: return 25;
      default: return 0;
    endcase
  endfunction

  task automatic add_cmd(command_t c, task_id_t id, task_dur_t dur);
    pending_cmds.push_back(task_cmd_t'{c, id, dur});
    if (c == CMD_PUSH) begin
      pushed_ids.push_back(id);
      if (pushed_ids.size() > RECENT_IDS) void'(pushed_ids.pop_front());
    end
  endtask

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Driver: predict on accept, then present the next pending item
  always @(posedge clk) begin
    task_cmd_t nxt_cmd;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(
          predict_task_result(task_cmd_t'{in_command, in_task_id, in_task_duration}));
        accepted_items <= accepted_items + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          nxt_cmd          = pending_cmds.pop_front();
          in_command       <= nxt_cmd.cmd;
          in_task_id       <= nxt_cmd.id;
          in_task_duration <= nxt_cmd.dur;
          in_valid         <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    task_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result: status %0d id %h dur %h",
                                  out_status, out_id, out_duration));
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status || out_id !== want.id || out_duration !== want.dur) begin
            flag_mismatch($sformatf(
              "mismatch: expected status %0d id %h dur %h, got status %0d id %h dur %h",
              want.status, want.id, want.dur, out_status, out_id, out_duration));
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct());
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int       push_pct;
    int       roll;
    task_id_t tid;
    push_pct = 50;

    // pop on empty, extremes of id and duration, duplicate on push
    add_cmd(CMD_POP,  16'hFFFF, 8'hFF);
    add_cmd(CMD_PUSH, 16'h0000, 8'h00);
    add_cmd(CMD_PUSH, 16'h0000, 8'h5A);
    add_cmd(CMD_PUSH, 16'hFFFF, 8'hFF);
    add_cmd(CMD_POP,  16'h1234, 8'h12);
    add_cmd(CMD_POP,  16'h0000, 8'h00);
    add_cmd(CMD_POP,  16'h0000, 8'h00);
    // fill the queue; duplicate of the newest entry just before it is full
    for (int k = 0; k < DEPTH - 1; k++) begin
      add_cmd(CMD_PUSH, task_id_t'(16'hA5A0 + k), 8'(k * 17));
    end
    add_cmd(CMD_PUSH, task_id_t'(16'hA5A0 + DEPTH - 2), 8'h33);
    add_cmd(CMD_PUSH, 16'h5A5F, 8'hC3);
    // full queue: new id and duplicate id both refused as full
    add_cmd(CMD_PUSH, 16'h7E81, 8'h81);
    add_cmd(CMD_PUSH, 16'hA5A0, 8'h7E);

    // random traffic in epochs that drift toward full, empty or balanced
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 48 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 85;
          1: push_pct = 15;
          default: push_pct = 55;
        endcase
      end
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < push_pct) begin
        if (roll < 8) begin
          tid = pushed_ids[pushed_ids.size() - 1];
        end else if (roll < 22) begin
          tid = pushed_ids[$urandom_range(0, pushed_ids.size() - 1)];
        end else if (roll < 26) begin
          tid = roll[0] ? 16'hFFFF : 16'h0000;
        end else begin
          tid = task_id_t'($urandom_range(0, 16'hFFFF));
        end
        add_cmd(CMD_PUSH, tid, task_dur_t'($urandom_range(0, 255)));
      end else begin
        add_cmd(CMD_POP, task_id_t'($urandom_range(0, 16'hFFFF)),
                task_dur_t'($urandom_range(0, 255)));
      end
    end
    total_cmds = pending_cmds.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_items < total_cmds) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/uitf_pkg.sv
hw/rtl/unique_id_task_fifo_unit.sv
sim/unique_id_task_fifo_unit_test.sv
